// ===== hw/rtl/pcm_pkg.sv =====
// Shared types and constants for the PWM capture measurement block.
`timescale 1ns / 1ps
`default_nettype none
package pcm_pkg;

  localparam int TIME_W   = 16;
  localparam int PERIOD_W = 17;
  localparam int TPS_W    = 24;
  localparam int DUTY_W   = 7;
  localparam int PROD_W   = 23;
  localparam int QUOT_W   = 24;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [TPS_W-1:0]  TPS_RESET  = 24'd1000000;
  localparam logic [DUTY_W-1:0] DUTY_SCALE = 7'd100;

  // register index, taken from paddr[2]
  localparam logic REG_TPS = 1'b0;

  typedef enum logic [1:0] {
    OP_ARM     = 2'b00,
    OP_CAPTURE = 2'b01
  } op_code_t;

  typedef enum logic [3:0] {
    P_RISE1 = 4'b0001,
    P_FALL  = 4'b0010,
    P_RISE2 = 4'b0100,
    P_DONE  = 4'b1000
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CALC  = 5'b00010,
    S_START = 5'b00100,
    S_DUTY  = 5'b01000,
    S_FREQ  = 5'b10000
  } seq_state_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pwm_capture_measure.sv =====
// Top level: edge sequencing, divide sequencer and result register.
// After a completing rising edge the sequencer runs setup, start and two passes of the shared
//   divider (duty, then frequency); a zero period skips both passes.
// Input: a completing edge blocks input until its result is in the output register,
//   including any wait on out_ready; other items do not block input.
// Reset (rst, synchronous): waits for a first rising edge, output empty, tick rate 1000000.
`timescale 1ns / 1ps
`default_nettype none
module pwm_capture_measure
  import pcm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic      [PDATA_W-1:0]  prdata,
  output logic                     pready,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                operation,
  input  wire logic                edge_rising,
  input  wire logic [TIME_W-1:0]   capture_time,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [DUTY_W-1:0]   duty_percent,
  output logic      [TPS_W-1:0]    frequency,
  output logic      [PERIOD_W-1:0] period_ticks,
  output logic      [TIME_W-1:0]   high_ticks,
  output logic                     status
);

  logic [TPS_W-1:0]    tps;
  seq_state_t          state;
  phase_t              phase;
  logic [TIME_W-1:0]   first_rise_time;
  logic [TIME_W-1:0]   fall_time;
  logic [TIME_W-1:0]   high_q;
  logic [TIME_W-1:0]   low_q;
  logic [PERIOD_W-1:0] period_q;
  logic [PROD_W-1:0]   prod_q;
  logic [DUTY_W-1:0]   duty_q;
  logic                in_acc;
  logic                out_free;
  logic                zero_period;
  logic                finish;
  logic                freq_done;
  div_ctl_t            div_ctl;
  logic [QUOT_W-1:0]   div_dividend;
  logic [QUOT_W-1:0]   div_quot;

  pcm_regs u_regs (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .ticks_per_second (tps)
  );

  assign in_ready    = (state == S_IDLE);
  assign in_acc      = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;
  assign zero_period = (period_q == '0);

  assign div_ctl.start = ((state == S_START) && !zero_period) ||
                         ((state == S_DUTY) && div_ctl.done);
  assign div_dividend  = (state == S_START) ? {1'b0, prod_q} : tps;

  // result ready to hand off to the output register
  assign finish = (((state == S_START) && zero_period) ||
                   ((state == S_FREQ) && (div_ctl.done || freq_done))) && out_free;

  pcm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_ctl.start),
    .dividend (div_dividend),
    .divisor  (period_q),
    .done     (div_ctl.done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      phase           <= P_RISE1;
      first_rise_time <= '0;
      fall_time       <= '0;
      freq_done       <= 1'b0;
    end else begin
      // frequency quotient stays valid while the output register is held
      if (finish) begin
        freq_done <= 1'b0;
      end else if ((state == S_FREQ) && div_ctl.done) begin
        freq_done <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if ({1'b0, operation} == OP_ARM) begin
              phase <= P_RISE1;
            end else begin
              unique case (phase)
                P_RISE1: begin
                  if (edge_rising) begin
                    first_rise_time <= capture_time;
                    phase           <= P_FALL;
                  end
                end
                P_FALL: begin
                  if (!edge_rising) begin
                    fall_time <= capture_time;
                    phase     <= P_RISE2;
                  end
                end
                P_RISE2: begin
                  if (edge_rising) begin
                    phase <= P_DONE;
                    state <= S_CALC;
                  end
                end
                P_DONE: begin
                end
                default: phase <= P_RISE1;
              endcase
            end
          end
        end
        S_CALC:  state <= S_START;
        S_START: begin
          if (!zero_period) begin
            state <= S_DUTY;
          end else if (finish) begin
            state <= S_IDLE;
          end
        end
        S_DUTY: begin
          if (div_ctl.done) begin
            state <= S_FREQ;
          end
        end
        S_FREQ: begin
          if (finish) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath; frequency quotient is held by the divider until handoff
  always_ff @(posedge clk) begin
    if (in_acc) begin
      high_q <= fall_time - first_rise_time;
      low_q  <= capture_time - fall_time;
    end
    if (state == S_CALC) begin
      period_q <= {1'b0, high_q} + {1'b0, low_q};
      prod_q   <= PROD_W'(high_q) * PROD_W'(DUTY_SCALE);
    end
    if ((state == S_DUTY) && div_ctl.done) begin
      duty_q <= div_quot[DUTY_W-1:0];
    end
  end

  // output register; a held result stalls the sequencer at its last step
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (zero_period) begin
        duty_percent <= '0;
        frequency    <= '0;
        period_ticks <= '0;
        high_ticks   <= '0;
        status       <= 1'b1;
      end else begin
        duty_percent <= duty_q;
        frequency    <= div_quot[TPS_W-1:0];
        period_ticks <= period_q;
        high_ticks   <= high_q;
        status       <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_zero_fields : assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (duty_percent == '0) && (frequency == '0) &&
                            (period_ticks == '0) && (high_ticks == '0))
    else $error("zero-period result carries nonzero fields");

  a_duty_range : assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> (duty_percent <= DUTY_SCALE))
    else $error("duty above full scale");

  a_div_owner : assert property (@(posedge clk) disable iff (rst)
    div_ctl.done |-> (state == S_DUTY) || (state == S_FREQ))
    else $error("divider finished outside a divide step");

  a_duty_to_freq : assert property (@(posedge clk) disable iff (rst)
    (state == S_DUTY) && div_ctl.done |=> (state == S_FREQ))
    else $error("frequency divide not started after duty");

  a_busy_blocks_input : assert property (@(posedge clk) disable iff (rst)
    (state == S_DUTY) |-> !in_ready && (phase == P_DONE))
    else $error("input open during divide");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/pcm_regs.sv =====
// APB configuration register file: timer tick rate.
`timescale 1ns / 1ps
`default_nettype none
module pcm_regs
  import pcm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output logic      [TPS_W-1:0]   ticks_per_second
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TPS);

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TPS_RESET;
    end else if (wr_en) begin
      ticks_per_second <= pwdata[TPS_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_TPS) ?
                  {{(PDATA_W-TPS_W){1'b0}}, ticks_per_second} : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/pcm_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pcm_div
  import pcm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [QUOT_W-1:0]   dividend,
  input  wire logic [PERIOD_W-1:0] divisor,
  output logic                     done,
  output logic      [QUOT_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(QUOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [PERIOD_W-1:0] rem;
  logic [PERIOD_W:0]   trial;
  logic                q_bit;

  assign trial = {rem, quotient[QUOT_W-1]} - {1'b0, divisor};
  assign q_bit = ~trial[PERIOD_W] | rem[PERIOD_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= q_bit ? trial[PERIOD_W-1:0] : {rem[PERIOD_W-2:0], quotient[QUOT_W-1]};
      quotient <= {quotient[QUOT_W-2:0], q_bit};
    end
  end

endmodule
`default_nettype wire

// ===== tb/pwm_capture_measure_check.sv =====
// Checker: predicts PWM capture measurements and compares them with the block's results.
`timescale 1ns / 1ps
module pwm_capture_measure_check
  import pcm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                operation,
  input  logic                edge_rising,
  input  logic [TIME_W-1:0]   capture_time,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [DUTY_W-1:0]   duty_percent,
  input  logic [TPS_W-1:0]    frequency,
  input  logic [PERIOD_W-1:0] period_ticks,
  input  logic [TIME_W-1:0]   high_ticks,
  input  logic                status,
  output int                  failures,
  output int                  pending,
  output int                  results_checked
);

  typedef struct packed {
    logic [DUTY_W-1:0]   duty;
    logic [TPS_W-1:0]    freq;
    logic [PERIOD_W-1:0] period;
    logic [TIME_W-1:0]   high;
    logic                status;
  } measurement_t;

  phase_t            meas_phase;
  logic [TIME_W-1:0] rise_time;
  logic [TIME_W-1:0] fall_time;
  logic [TPS_W-1:0]  tick_rate;
  measurement_t      measurements_due[$];
  int                fail_count = 0;
  int                checked = 0;

  initial begin
    failures = 0;
    pending = 0;
    results_checked = 0;
  end

  // advance the edge sequence; returns 1 when a measurement completes
  function automatic bit predict_measurement(input logic op, input logic rising,
                                             input logic [TIME_W-1:0] t,
                                             output measurement_t m);
    logic [TIME_W-1:0]   hi;
    logic [TIME_W-1:0]   lo;
    logic [PERIOD_W-1:0] per;
    m = '0;
    if ({1'b0, op} == OP_ARM) begin
      meas_phase = P_RISE1;
      return 1'b0;
    end
    case (meas_phase)
      P_RISE1: if (rising) begin
        rise_time  = t;
        meas_phase = P_FALL;
      end
      P_FALL: if (!rising) begin
        fall_time  = t;
        meas_phase = P_RISE2;
      end
      P_RISE2: if (rising) begin
        meas_phase = P_DONE;
        hi  = fall_time - rise_time;
        lo  = t - fall_time;
        per = {1'b0, hi} + {1'b0, lo};
        if (per == '0) begin
          m.status = 1'b1;
        end else begin
          m.duty   = DUTY_W'((32'(hi) * 32'(DUTY_SCALE)) / 32'(per));
          m.freq   = TPS_W'(32'(tick_rate) / 32'(per));
          m.period = per;
          m.high   = hi;
        end
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic int field_diff(input string name, input int unsigned want,
                                    input int unsigned got);
    if (want == got) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : track
    measurement_t want;
    measurement_t m;
    if (rst) begin
      tick_rate  = TPS_RESET;
      meas_phase = P_RISE1;
      rise_time  = '0;
      fall_time  = '0;
      measurements_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1] == REG_TPS)
        tick_rate = pwdata[TPS_W-1:0];
      if (out_valid && out_ready) begin
        if (measurements_due.size() == 0) begin
          $error("result with no measurement pending: duty %0d freq %0d period %0d",
                 duty_percent, frequency, period_ticks);
          fail_count++;
        end else begin
          want = measurements_due.pop_front();
          fail_count += field_diff("duty_percent", 32'(want.duty), 32'(duty_percent));
          fail_count += field_diff("frequency", 32'(want.freq), 32'(frequency));
          fail_count += field_diff("period_ticks", 32'(want.period), 32'(period_ticks));
          fail_count += field_diff("high_ticks", 32'(want.high), 32'(high_ticks));
          fail_count += field_diff("status", 32'(want.status), 32'(status));
          checked++;
        end
      end
      if (in_valid && in_ready &&
          predict_measurement(operation, edge_rising, capture_time, m))
        measurements_due.push_back(m);
    end
    failures        <= fail_count;
    pending         <= measurements_due.size();
    results_checked <= checked;
  end

endmodule

// ===== tb/pwm_capture_measure_test.sv =====
// Testbench top: clock, reset, register writes, capture stimulus and verdict.
`timescale 1ns / 1ps
module pwm_capture_measure_test;
  import pcm_pkg::*;

  localparam int LIMIT        = 1_000_000;
  localparam int SETTLE       = 60;
  localparam int PHASES       = 6;
  localparam int RANDOM_ITEMS = 1000;

  localparam logic ARM_OP     = 1'(OP_ARM);
  localparam logic CAPTURE_OP = 1'(OP_CAPTURE);
  localparam logic RISING     = 1'b1;
  localparam logic FALLING    = 1'b0;

  localparam logic [PADDR_W-1:0] TPS_ADDR   = {REG_TPS, 2'b00};
  localparam logic [PADDR_W-1:0] SPARE_ADDR = {~REG_TPS, 2'b00};

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                operation = 1'b0;
  logic                edge_rising = 1'b0;
  logic [TIME_W-1:0]   capture_time = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DUTY_W-1:0]   duty_percent;
  logic [TPS_W-1:0]    frequency;
  logic [PERIOD_W-1:0] period_ticks;
  logic [TIME_W-1:0]   high_ticks;
  logic                status;

  int failures;
  int pending;
  int results_checked;
  int cycle_count = 0;
  int sent = 0;
  int settings = 1;
  int idle_pct = 0;
  int stall_left = 0;
  int idle_plan [PHASES] = '{30, 0, 60, 15, 40, 0};

  pwm_capture_measure dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .edge_rising(edge_rising), .capture_time(capture_time),
    .out_valid(out_valid), .out_ready(out_ready), .duty_percent(duty_percent),
    .frequency(frequency), .period_ticks(period_ticks), .high_ticks(high_ticks),
    .status(status)
  );

  pwm_capture_measure_check measure_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .edge_rising(edge_rising), .capture_time(capture_time),
    .out_valid(out_valid), .out_ready(out_ready), .duty_percent(duty_percent),
    .frequency(frequency), .period_ticks(period_ticks), .high_ticks(high_ticks),
    .status(status),
    .failures(failures), .pending(pending), .results_checked(results_checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT);
    $display("Timeout after %0d cycles", cycle_count);
    $display("Mismatches found");
    $finish;
  end

  // result-side backpressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < idle_pct) stall_left = $urandom_range(1, 11);
    end
  end

  task automatic send(input logic op, input logic rising, input logic [TIME_W-1:0] t);
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    edge_rising  <= rising;
    capture_time <= t;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic arm();
    send(ARM_OP, 1'($urandom_range(0, 1)), TIME_W'($urandom));
  endtask

  task automatic edge_at(input logic rising, input logic [TIME_W-1:0] t);
    send(CAPTURE_OP, rising, t);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drain all pending measurements, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [TIME_W-1:0] span();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return TIME_W'($urandom_range(1, 255));
      3: return TIME_W'($urandom_range(1, 4095));
      default: return TIME_W'($urandom);
    endcase
  endfunction

  // mostly complete rise/fall/rise sequences, some noise and broken ones
  task automatic random_burst();
    logic [TIME_W-1:0] t;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 4))
        send(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), TIME_W'($urandom));
      return;
    end
    arm();
    if ($urandom_range(0, 5) == 0) edge_at(FALLING, TIME_W'($urandom));
    t = TIME_W'($urandom);
    edge_at(RISING, t);
    if ($urandom_range(0, 5) == 0) edge_at(RISING, TIME_W'($urandom));
    t += span();
    edge_at(FALLING, t);
    if ($urandom_range(0, 9) == 0) return;
    if ($urandom_range(0, 5) == 0) edge_at(FALLING, TIME_W'($urandom));
    t += span();
    edge_at(RISING, t);
    if ($urandom_range(0, 4) == 0) edge_at(1'($urandom_range(0, 1)), TIME_W'($urandom));
  endtask

  initial begin
    logic [TPS_W-1:0] tps;
    int target;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    idle_pct = 25;

    // zero period straight out of reset
    edge_at(RISING, 16'h0000);
    edge_at(FALLING, 16'h0000);
    edge_at(RISING, 16'h0000);
    // wrapped times, wrong polarity edges, edges after completion
    arm();
    edge_at(RISING, 16'hFFFF);
    edge_at(RISING, 16'h1234);
    edge_at(FALLING, 16'h0000);
    edge_at(FALLING, 16'h5555);
    edge_at(RISING, 16'hFFFF);
    edge_at(RISING, 16'h0100);
    edge_at(FALLING, 16'h0200);
    // longest period
    arm();
    edge_at(RISING, 16'h0000);
    edge_at(FALLING, 16'hFFFF);
    edge_at(RISING, 16'hFFFE);
    // zero high time
    arm();
    edge_at(RISING, 16'h0005);
    edge_at(FALLING, 16'h0005);
    edge_at(RISING, 16'h000A);
    // zero low time, full duty
    arm();
    edge_at(RISING, 16'h0000);
    edge_at(FALLING, 16'h0064);
    edge_at(RISING, 16'h0064);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: tps = '1;
        1: tps = TPS_W'(1);
        default: tps = TPS_W'($urandom_range(1, 24'hFFFFFF));
      endcase
      if (ph == 2) write_reg(SPARE_ADDR, $urandom);
      write_reg(TPS_ADDR, PDATA_W'(tps));
      settings++;
      idle_pct = idle_plan[ph];
      // one-tick period at this tick rate
      arm();
      edge_at(RISING, 16'h0000);
      edge_at(FALLING, 16'h0001);
      edge_at(RISING, 16'h0001);
      target = sent + RANDOM_ITEMS / PHASES;
      while (sent < target) random_burst();
      settle();
    end

    $display("Covered %0d capture/arm requests under %0d tick-rate settings,",
             sent, settings);
    $display("with %0d period measurements compared field by field.", results_checked);
    if (failures == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pcm_pkg.sv
hw/rtl/pcm_regs.sv
hw/rtl/pcm_div.sv
hw/rtl/pwm_capture_measure.sv
tb/pwm_capture_measure_check.sv
tb/pwm_capture_measure_test.sv
